[sv/deq_pkg.sv]
package deq_pkg;

    // Default capacity of the ring store
    localparam int DEQ_DEPTH = 16;

    // Fixed field widths
    localparam int MODE_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    // Operation codes carried on s_tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_REAR  = 3'd1,
        MODE_DEL_FRONT = 3'd2,
        MODE_DEL_REAR  = 3'd3,
        MODE_ERASE     = 3'd4
    } deq_mode_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } deq_status_t;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } deq_state_t;

    // Controller to datapath
    typedef struct packed {
        logic exec;   // apply the accepted operation to pointers, count and store
        logic rd;     // read front and rear entries of the store
        logic load;   // move the result into the output register
    } deq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;  // output register holds a word that is not taken this cycle
    } deq_stat_t;

endpackage

[sv/double_ended_queue_core.sv]
// Double-ended queue on a ring store, one operation per input word.
// An accepted operation goes through execute, store read and output load in turn;
// the load waits while the previous result is untaken;
// the next operation is accepted while a result still waits on m_tready.
// Reset (aresetn low, synchronous): pointers and count cleared, output empty;
// store contents are not cleared.
module double_ended_queue_core #(
    parameter  int DEPTH   = deq_pkg::DEQ_DEPTH,
    localparam int CW      = $clog2(DEPTH + 1),
    localparam int TDATA_W = ((2 * deq_pkg::WORD_W + deq_pkg::STATUS_W + CW + 1 + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Operation channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [deq_pkg::WORD_W-1:0]    s_tdata,   // data
    input  logic [deq_pkg::MODE_W-1:0]    s_tuser,   // mode
    // Result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [TDATA_W-1:0]            m_tdata    // status, front_word, rear_word,
                                                     // count, is_empty, zero fill
);
    import deq_pkg::*;

    localparam int FRONT_LSB = STATUS_W;
    localparam int REAR_LSB  = FRONT_LSB + WORD_W;
    localparam int CNT_LSB   = REAR_LSB + WORD_W;
    localparam int EMPTY_BIT = CNT_LSB + CW;

    deq_cmd_t                 cmd;
    deq_stat_t                stat;
    logic [STATUS_W-1:0]      out_status;
    logic signed [WORD_W-1:0] out_front;
    logic signed [WORD_W-1:0] out_rear;
    logic [CW-1:0]            out_count;
    logic                     out_empty;

    deq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_mode    (s_tuser),
        .in_data    (s_tdata),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_status (out_status),
        .out_front  (out_front),
        .out_rear   (out_rear),
        .out_count  (out_count),
        .out_empty  (out_empty)
    );

    // Pack the result word, zero fill on top
    assign m_tdata = TDATA_W'({out_empty, out_count, out_rear, out_front, out_status});

`ifndef SYNTHESIS
    // Count never exceeds capacity
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[CNT_LSB +: CW] <= CW'(DEPTH)))
        else $error("result count above capacity");

    // Empty flag agrees with count
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[EMPTY_BIT] == (m_tdata[CNT_LSB +: CW] == '0)))
        else $error("empty flag disagrees with count");

    // Empty deque reports all-ones words
    a_empty_words: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[EMPTY_BIT]) |->
            ((m_tdata[FRONT_LSB +: WORD_W] == '1) && (m_tdata[REAR_LSB +: WORD_W] == '1)))
        else $error("empty result with stored words");

    // One operation in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("operation accepted while another is in progress");
`endif

endmodule

[sv/deq_ctrl.sv]
module deq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  deq_pkg::deq_stat_t stat,
    output deq_pkg::deq_cmd_t  cmd
);
    import deq_pkg::*;

    deq_state_t state_reg;
    deq_state_t state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.exec   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (!stat.out_busy) begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/deq_dp.sv]
module deq_dp #(
    parameter  int DEPTH = deq_pkg::DEQ_DEPTH,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  deq_pkg::deq_cmd_t                   cmd,
    output deq_pkg::deq_stat_t                  stat,
    input  logic [deq_pkg::MODE_W-1:0]          in_mode,
    input  logic signed [deq_pkg::WORD_W-1:0]   in_data,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [deq_pkg::STATUS_W-1:0]        out_status,
    output logic signed [deq_pkg::WORD_W-1:0]   out_front,
    output logic signed [deq_pkg::WORD_W-1:0]   out_rear,
    output logic [CW-1:0]                       out_count,
    output logic                                out_empty
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // Ring store
    logic signed [WORD_W-1:0] mem [DEPTH];

    logic [AW-1:0]            head_reg, head_next;
    logic [AW-1:0]            tail_reg, tail_next;
    logic [CW-1:0]            fill_reg, fill_next;
    logic [STATUS_W-1:0]      st_reg, st_next;
    logic                     we;
    logic [AW-1:0]            waddr;
    logic signed [WORD_W-1:0] front_rd_reg, rear_rd_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]      out_status_reg;
    logic signed [WORD_W-1:0] out_front_reg, out_rear_reg;
    logic [CW-1:0]            out_count_reg;
    logic                     out_empty_reg;
    logic                     full, empty;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    assign full  = (fill_reg == FULL_CNT);
    assign empty = (fill_reg == '0);

    // Operation: pointer, count and status update, store write
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        st_next   = st_reg;
        we        = 1'b0;
        waddr     = head_reg;
        if (cmd.exec) begin
            st_next = ST_OK;
            unique case (in_mode)
                MODE_INS_FRONT, MODE_INS_REAR: begin
                    if (full) begin
                        st_next = ST_OVERFLOW;
                    end else begin
                        we        = 1'b1;
                        fill_next = fill_reg + 1'b1;
                        if (empty) begin
                            tail_next = head_reg;
                            waddr     = head_reg;
                        end else if (in_mode == MODE_INS_FRONT) begin
                            head_next = idx_dec(head_reg);
                            waddr     = head_next;
                        end else begin
                            tail_next = idx_inc(tail_reg);
                            waddr     = tail_next;
                        end
                    end
                end
                MODE_DEL_FRONT, MODE_DEL_REAR: begin
                    if (empty) begin
                        st_next = ST_UNDERFLOW;
                    end else begin
                        fill_next = fill_reg - 1'b1;
                        if (fill_reg != CW'(1)) begin
                            if (in_mode == MODE_DEL_FRONT) begin
                                head_next = idx_inc(head_reg);
                            end else begin
                                tail_next = idx_dec(tail_reg);
                            end
                        end
                    end
                end
                MODE_ERASE: begin
                    fill_next = '0;
                    head_next = '0;
                    tail_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // Status of the last operation
    always_ff @(posedge aclk) begin
        st_reg <= st_next;
    end

    // Store write and registered reads at head and tail
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= in_data;
        end
        if (cmd.rd) begin
            front_rd_reg <= mem[head_reg];
            rear_rd_reg  <= mem[tail_reg];
        end
    end

    // Output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_status_reg <= st_reg;
            out_front_reg  <= empty ? '1 : front_rd_reg;
            out_rear_reg   <= empty ? '1 : rear_rd_reg;
            out_count_reg  <= fill_reg;
            out_empty_reg  <= empty;
        end
    end

    assign stat.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid      = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_front     = out_front_reg;
    assign out_rear      = out_rear_reg;
    assign out_count     = out_count_reg;
    assign out_empty     = out_empty_reg;

endmodule
